// ===== rtl/t8sd_pkg.sv =====
package t8sd_pkg;

  localparam logic [7:0] PAD_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ROLE_TAG = 2'd0,
    ROLE_LEN = 2'd1,
    ROLE_VAL = 2'd2
  } role_t;

  typedef enum logic [2:0] {
    PH_TAG = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } phase_t;

endpackage

// ===== rtl/t8sd_if.sv =====
interface t8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface t8sd_out_if import t8sd_pkg::*;;
  logic       valid;
  logic       ready;
  role_t      byte_role;
  logic [7:0] element_tag;
  logic [7:0] element_length;
  logic [7:0] value_byte;
  logic [7:0] value_index;
  logic       element_complete;
  logic       stream_done;
  logic       stream_ok;

  modport source (output valid, byte_role, element_tag, element_length, value_byte,
                  value_index, element_complete, stream_done, stream_ok, input ready);
  modport sink (input valid, byte_role, element_tag, element_length, value_byte,
                value_index, element_complete, stream_done, stream_ok, output ready);
endinterface

// ===== rtl/tlv8_stream_decoder.sv =====
// Tag-length-value stream decoder with one-byte tag and one-byte length.
//
// in_bus carries the raw buffer one byte per transfer; last_byte marks the
// final byte of a buffer. Each transfer produces exactly one result on
// out_bus: the role of the byte (tag, length or value), the tag and declared
// length of its element, the value byte and its index, and a flag on the byte
// that completes an element. The result for the final byte also carries
// stream_done and stream_ok; stream_ok is low when a trailing incomplete
// element holds any byte other than 0xFF, and the consumer then drops the
// elements it has collected from that buffer.
//
// An input transfer's result is registered and appears in the cycle after it.
// Throughput is one byte per cycle unless the receiver stalls, set by the
// single result register that the parser state update feeds. in_bus.ready
// stays high while that register is empty or drained in the same cycle, so a
// receiver stall holds the pending result and backs up the input by one entry.
// Reset empties the result register and puts the parser back to expecting a
// tag byte; the parser also returns to that state after every final byte.
module tlv8_stream_decoder import t8sd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  t8sd_in_if.sink     in_bus,
  t8sd_out_if.source  out_bus
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] tag_r, tag_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       all_ff_r, all_ff_nxt;

  logic       out_valid_r;
  role_t      role_r, role_nxt;
  logic [7:0] etag_r, etag_nxt;
  logic [7:0] elen_r, elen_nxt;
  logic [7:0] vbyte_r, vbyte_nxt;
  logic [7:0] vidx_r, vidx_nxt;
  logic       cmpl_r, cmpl_nxt;
  logic       done_r, done_nxt;
  logic       ok_r, ok_nxt;

  logic       in_fire;
  logic       is_ff;
  logic [7:0] cnt_inc;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign is_ff        = (in_bus.data_byte == PAD_BYTE);
  assign cnt_inc      = cnt_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    all_ff_nxt = all_ff_r;
    role_nxt   = ROLE_TAG;
    etag_nxt   = tag_r;
    elen_nxt   = len_r;
    vbyte_nxt  = 8'd0;
    vidx_nxt   = 8'd0;
    cmpl_nxt   = 1'b0;
    done_nxt   = 1'b0;
    ok_nxt     = 1'b0;

    case (phase_r)
      PH_LEN: begin
        role_nxt   = ROLE_LEN;
        len_nxt    = in_bus.data_byte;
        elen_nxt   = in_bus.data_byte;
        all_ff_nxt = all_ff_r && is_ff;
        cnt_nxt    = 8'd0;
        if (in_bus.data_byte == 8'd0) begin
          cmpl_nxt  = 1'b1;
          phase_nxt = PH_TAG;
        end else begin
          phase_nxt = PH_VAL;
        end
      end
      PH_VAL: begin
        role_nxt   = ROLE_VAL;
        all_ff_nxt = all_ff_r && is_ff;
        vbyte_nxt  = in_bus.data_byte;
        vidx_nxt   = cnt_r;
        cnt_nxt    = cnt_inc;
        if (cnt_inc == len_r) begin
          cmpl_nxt  = 1'b1;
          phase_nxt = PH_TAG;
        end
      end
      default: begin
        role_nxt   = ROLE_TAG;
        tag_nxt    = in_bus.data_byte;
        etag_nxt   = in_bus.data_byte;
        len_nxt    = 8'd0;
        elen_nxt   = 8'd0;
        cnt_nxt    = 8'd0;
        all_ff_nxt = is_ff;
        phase_nxt  = PH_LEN;
      end
    endcase

    // The final byte closes the buffer and returns the parser to its reset state.
    if (in_bus.last_byte) begin
      done_nxt   = 1'b1;
      ok_nxt     = cmpl_nxt || all_ff_nxt;
      phase_nxt  = PH_TAG;
      tag_nxt    = 8'd0;
      len_nxt    = 8'd0;
      cnt_nxt    = 8'd0;
      all_ff_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG;
      tag_r       <= 8'd0;
      len_r       <= 8'd0;
      cnt_r       <= 8'd0;
      all_ff_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        tag_r       <= tag_nxt;
        len_r       <= len_nxt;
        cnt_r       <= cnt_nxt;
        all_ff_r    <= all_ff_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      role_r  <= role_nxt;
      etag_r  <= etag_nxt;
      elen_r  <= elen_nxt;
      vbyte_r <= vbyte_nxt;
      vidx_r  <= vidx_nxt;
      cmpl_r  <= cmpl_nxt;
      done_r  <= done_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.byte_role        = role_r;
  assign out_bus.element_tag      = etag_r;
  assign out_bus.element_length   = elen_r;
  assign out_bus.value_byte       = vbyte_r;
  assign out_bus.value_index      = vidx_r;
  assign out_bus.element_complete = cmpl_r;
  assign out_bus.stream_done      = done_r;
  assign out_bus.stream_ok        = ok_r;

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!ok_r || done_r))
    else $error("stream_ok raised without stream_done");

  a_tag_never_completes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(cmpl_r && role_r == ROLE_TAG))
    else $error("tag byte flagged as completing an element");

  a_last_resets_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.last_byte) |=> (phase_r == PH_TAG && all_ff_r && cnt_r == 8'd0))
    else $error("parser not returned to tag phase after final byte");

  a_value_follows_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_VAL) |=> (vidx_r == $past(cnt_r) && elen_r == $past(len_r)))
    else $error("value result does not match held element state");

endmodule
